>>> rtl/pfb_pkg.sv
// ============================================================================
// pfb_pkg
// Shared codes and types for the page framebuffer tile blitter.
// ============================================================================
package pfb_pkg;

    // Item function codes as they arrive on the input channel.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_MERGE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Memory operations that the front end hands to the back end.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_MERGE = 2'd3;

    // Address width that covers the largest supported framebuffer.
    localparam int ADDR_W = 12;

    // One classified command, as it sits in the queue.
    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr_main;
        logic              main_ok;
        logic [7:0]        val_main;
        logic [ADDR_W-1:0] addr_spill;
        logic              spill_ok;
        logic [7:0]        val_spill;
        logic [7:0]        tile_advance;
        logic              tile_done;
        logic              dropped;
    } pfb_cmd_t;

endpackage

>>> rtl/pfb_in_if.sv
// ============================================================================
// pfb_in_if
// Input channel: one item beat per valid/ready handshake.
// ============================================================================
interface pfb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [9:0] address;
    logic [7:0] data;
    logic [6:0] cursor_x;
    logic [5:0] cursor_y;
    logic [7:0] tile_width;
    logic [7:0] tile_height;

    modport source (output valid, func, address, data, cursor_x, cursor_y,
                    tile_width, tile_height, input ready);
    modport sink   (input valid, func, address, data, cursor_x, cursor_y,
                    tile_width, tile_height, output ready);
endinterface

>>> rtl/pfb_out_if.sv
// ============================================================================
// pfb_out_if
// Result channel: one result beat per valid/ready handshake.
// ============================================================================
interface pfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] tile_advance;
    logic       tile_done;
    logic       dropped;

    modport source (output valid, read_data, tile_advance, tile_done, dropped,
                    input ready);
    modport sink   (input valid, read_data, tile_advance, tile_done, dropped,
                    output ready);
endinterface

>>> rtl/pfb_front.sv
// ============================================================================
// pfb_front
// Accepts items, keeps the tile cursor state and turns each item into a
// memory command with its result fields already worked out.
// ============================================================================
module pfb_front #(
    parameter int FB_COLUMNS = 128,
    parameter int FB_BYTES   = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    pfb_in_if.sink              item_in,
    input  logic                clear_busy,
    output logic                push_valid,
    input  logic                push_ready,
    output pfb_pkg::pfb_cmd_t   push_cmd
);
    import pfb_pkg::*;

    localparam int COL_W = $clog2(FB_COLUMNS + 1);
    localparam int LIN_W = 9 + COL_W + 1;
    localparam int PAGES = FB_BYTES / FB_COLUMNS;

    logic [6:0] base_column_reg,  base_column_next;
    logic [8:0] current_page_reg, current_page_next;
    logic [2:0] bit_shift_reg,    bit_shift_next;
    logic [7:0] column_count_reg, column_count_next;
    logic [7:0] rows_left_reg,    rows_left_next;
    logic [7:0] width_held_reg,   width_held_next;
    logic       tile_active_reg,  tile_active_next;

    logic             accept;
    logic [LIN_W-1:0] page_base;
    logic [LIN_W-1:0] lin_main;
    logic [LIN_W-1:0] lin_spill;
    logic             main_ok;
    logic             spill_en;
    logic             spill_ok;
    logic [15:0]      shifted;
    logic [7:0]       col_inc;
    logic [7:0]       rows_dec;
    logic             addr_in_range;

    assign item_in.ready = push_ready && !clear_busy;
    assign accept        = item_in.valid && item_in.ready;
    assign push_valid    = item_in.valid && !clear_busy;

    // Byte address of the current tile column and of its spill byte below.
    assign page_base = LIN_W'(current_page_reg) * LIN_W'(FB_COLUMNS);
    assign lin_main  = page_base + LIN_W'(base_column_reg) + LIN_W'(column_count_reg);
    assign lin_spill = lin_main + LIN_W'(FB_COLUMNS);
    assign main_ok   = lin_main < LIN_W'(FB_BYTES);
    assign spill_en  = (bit_shift_reg != 3'd0)
                    && ((10'(current_page_reg) + 10'd2) <= 10'(PAGES));
    assign spill_ok  = spill_en && (lin_spill < LIN_W'(FB_BYTES));
    assign shifted   = {8'd0, item_in.data} << bit_shift_reg;
    assign col_inc   = column_count_reg + 8'd1;
    assign rows_dec  = rows_left_reg - 8'd1;
    assign addr_in_range = {3'd0, item_in.address} < 13'(FB_BYTES);

    // Classify the item and work out the next tile state.
    always_comb
    begin
        base_column_next  = base_column_reg;
        current_page_next = current_page_reg;
        bit_shift_next    = bit_shift_reg;
        column_count_next = column_count_reg;
        rows_left_next    = rows_left_reg;
        width_held_next   = width_held_reg;
        tile_active_next  = tile_active_reg;

        push_cmd              = '0;
        push_cmd.op           = OP_NONE;
        push_cmd.addr_main    = ADDR_W'(item_in.address);
        push_cmd.val_main     = item_in.data;

        case (item_in.func)
            FUNC_WRITE:
            begin
                push_cmd.op      = OP_WRITE;
                push_cmd.main_ok = addr_in_range;
                push_cmd.dropped = !addr_in_range;
            end
            FUNC_START:
            begin
                base_column_next      = item_in.cursor_x;
                current_page_next     = 9'(item_in.cursor_y[5:3]);
                bit_shift_next        = item_in.cursor_y[2:0];
                width_held_next       = item_in.tile_width;
                rows_left_next        = item_in.tile_height;
                column_count_next     = 8'd0;
                tile_active_next      = (item_in.tile_width != 8'd0)
                                     && (item_in.tile_height != 8'd0);
                push_cmd.tile_advance = item_in.tile_width;
            end
            FUNC_MERGE:
            begin
                if (!tile_active_reg)
                begin
                    push_cmd.dropped = 1'b1;
                end
                else
                begin
                    push_cmd.op         = OP_MERGE;
                    push_cmd.addr_main  = ADDR_W'(lin_main);
                    push_cmd.main_ok    = main_ok;
                    push_cmd.val_main   = shifted[7:0];
                    push_cmd.addr_spill = ADDR_W'(lin_spill);
                    push_cmd.spill_ok   = spill_ok;
                    push_cmd.val_spill  = shifted[15:8];
                    push_cmd.dropped    = !main_ok || (spill_en && !spill_ok);
                    column_count_next   = col_inc;
                    if (col_inc == width_held_reg)
                    begin
                        column_count_next = 8'd0;
                        current_page_next = current_page_reg + 9'd1;
                        rows_left_next    = rows_dec;
                        if (rows_dec == 8'd0)
                        begin
                            push_cmd.tile_done = 1'b1;
                            tile_active_next   = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                push_cmd.op = addr_in_range ? OP_READ : OP_NONE;
            end
        endcase
    end

    // Tile state only moves on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_column_reg  <= '0;
            current_page_reg <= '0;
            bit_shift_reg    <= '0;
            column_count_reg <= '0;
            rows_left_reg    <= '0;
            width_held_reg   <= '0;
            tile_active_reg  <= 1'b0;
        end
        else if (accept)
        begin
            base_column_reg  <= base_column_next;
            current_page_reg <= current_page_next;
            bit_shift_reg    <= bit_shift_next;
            column_count_reg <= column_count_next;
            rows_left_reg    <= rows_left_next;
            width_held_reg   <= width_held_next;
            tile_active_reg  <= tile_active_next;
        end
    end

endmodule

>>> rtl/pfb_queue.sv
// ============================================================================
// pfb_queue
// Two-entry command queue between the front end and the memory engine.
// ============================================================================
module pfb_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  pfb_pkg::pfb_cmd_t   push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output pfb_pkg::pfb_cmd_t   pop_cmd
);
    import pfb_pkg::*;

    pfb_cmd_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/pfb_back.sv
// ============================================================================
// pfb_back
// Memory engine: clears the framebuffer after reset, carries out the queued
// writes, reads and read-modify-write merges, and holds the result register.
// ============================================================================
module pfb_back #(
    parameter int FB_BYTES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  pfb_pkg::pfb_cmd_t   pop_cmd,
    output logic                clear_busy,
    pfb_out_if.source           result_out
);
    import pfb_pkg::*;

    localparam int AW = $clog2(FB_BYTES);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MRG_A = 3'd3;
    localparam logic [2:0] ST_MRG_B = 3'd4;

    logic [7:0]    mem [FB_BYTES];
    logic [7:0]    rdata_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    pfb_cmd_t      cmd_reg, cmd_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    read_data_reg, read_data_next;
    logic [7:0]    tile_advance_reg, tile_advance_next;
    logic          tile_done_reg, tile_done_next;
    logic          dropped_reg, dropped_next;

    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;
    logic [AW-1:0] ra;
    logic          finish;
    pfb_cmd_t      fin_cmd;
    logic [7:0]    fin_rd;

    assign clear_busy = state_reg == ST_CLEAR;
    assign pop_ready  = (state_reg == ST_IDLE)
                     && (!out_valid_reg || result_out.ready);

    assign result_out.valid        = out_valid_reg;
    assign result_out.read_data    = read_data_reg;
    assign result_out.tile_advance = tile_advance_reg;
    assign result_out.tile_done    = tile_done_reg;
    assign result_out.dropped      = dropped_reg;

    // Sequencer: one memory write and one memory read per cycle at most.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd_next     = cmd_reg;
        we           = 1'b0;
        wa           = cmd_reg.addr_main[AW-1:0];
        wd           = 8'd0;
        ra           = cmd_reg.addr_main[AW-1:0];
        finish       = 1'b0;
        fin_cmd      = cmd_reg;
        fin_rd       = 8'd0;

        case (state_reg)
            ST_CLEAR:
            begin
                we           = 1'b1;
                wa           = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(FB_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ra = pop_cmd.addr_main[AW-1:0];
                if (pop_valid && pop_ready)
                begin
                    cmd_next = pop_cmd;
                    case (pop_cmd.op)
                        OP_WRITE:
                        begin
                            we      = pop_cmd.main_ok;
                            wa      = pop_cmd.addr_main[AW-1:0];
                            wd      = pop_cmd.val_main;
                            finish  = 1'b1;
                            fin_cmd = pop_cmd;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        OP_MERGE:
                        begin
                            state_next = ST_MRG_A;
                        end
                        default:
                        begin
                            finish  = 1'b1;
                            fin_cmd = pop_cmd;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                finish     = 1'b1;
                fin_rd     = rdata_reg;
                state_next = ST_IDLE;
            end
            ST_MRG_A:
            begin
                // Main byte is back: write it and fetch the spill byte.
                we         = cmd_reg.main_ok;
                wd         = rdata_reg | cmd_reg.val_main;
                ra         = cmd_reg.addr_spill[AW-1:0];
                state_next = ST_MRG_B;
            end
            ST_MRG_B:
            begin
                we         = cmd_reg.spill_ok;
                wa         = cmd_reg.addr_spill[AW-1:0];
                wd         = rdata_reg | cmd_reg.val_spill;
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register loads when a command finishes.
    always_comb
    begin
        out_valid_next    = out_valid_reg && !result_out.ready;
        read_data_next    = read_data_reg;
        tile_advance_next = tile_advance_reg;
        tile_done_next    = tile_done_reg;
        dropped_next      = dropped_reg;
        if (finish)
        begin
            out_valid_next    = 1'b1;
            read_data_next    = fin_rd;
            tile_advance_next = fin_cmd.tile_advance;
            tile_done_next    = fin_cmd.tile_done;
            dropped_next      = fin_cmd.dropped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        read_data_reg    <= read_data_next;
        tile_advance_reg <= tile_advance_next;
        tile_done_reg    <= tile_done_next;
        dropped_reg      <= dropped_next;
    end

    // Framebuffer memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[ra];
    end

endmodule

>>> rtl/page_framebuffer_tile_blit_unit.sv
// ============================================================================
// page_framebuffer_tile_blit_unit
// Monochrome page framebuffer with byte write, byte read and tile merge.
// ============================================================================
// Usage: items arrive on item_in (func, address, data, cursor and tile size)
// and every item gives exactly one beat on result_out. A write stores a byte,
// a read returns one in read_data, a start tile echoes its width in
// tile_advance, and a merge ORs a column byte into the current page and the
// spilled bits into the page below. tile_done marks the last merged byte of a
// tile; dropped flags tileless merges and writes or merges past the buffer.
// Each command passes through the queue to the memory engine. A write, a
// start tile or a merge with no tile finishes as it is popped, a read waits
// in ST_READ for the registered read, and a merge steps through ST_MRG_A and
// ST_MRG_B, a read-modify-write sequence on the single write port.
// A two-entry command queue lets the front end take beats while the engine
// works or while a finished result waits in the output register; a stalled
// receiver backs up into the queue and then into item_in.ready.
// After reset the engine sweeps zeros through all FB_BYTES bytes of the
// framebuffer, one byte per cycle; item_in.ready stays low until it ends.
// ============================================================================
module page_framebuffer_tile_blit_unit #(
    parameter int FB_COLUMNS = 128,
    parameter int FB_BYTES   = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    pfb_in_if.sink    item_in,
    pfb_out_if.source result_out
);
    import pfb_pkg::*;

    logic     push_valid;
    logic     push_ready;
    pfb_cmd_t push_cmd;
    logic     pop_valid;
    logic     pop_ready;
    pfb_cmd_t pop_cmd;
    logic     clear_busy;

    pfb_front #(
        .FB_COLUMNS (FB_COLUMNS),
        .FB_BYTES   (FB_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .clear_busy (clear_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    pfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    pfb_back #(
        .FB_BYTES (FB_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .clear_busy (clear_busy),
        .result_out (result_out)
    );

endmodule
